### rtl/sle_pkg.sv
package sle_pkg;
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int FIDX_W   = 6;
    localparam int LEN_W    = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_LOCATE = 3'd2,
        CMD_PURGE  = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIDX_W-1:0]   found_index;
        logic [LEN_W-1:0]    length;
        logic                is_empty;
    } t_out_beat;
endpackage

### rtl/sle_if.sv
interface sle_in_if;
    logic               valid;
    logic               ready;
    sle_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sle_out_if;
    logic               valid;
    logic               ready;
    sle_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/sle_ram.sv
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/sequential_list_engine_unit.sv
// Clear, unknown and refused commands go straight to the result; insert and delete move each
// entry with a read and then a write; locate reads entries from index 0 until a hit or the
// end of the list. Purge compares each entry with the kept ones and writes back only values
// not kept yet. One command is in work at a time; the next beat is taken only after the
// result is registered.
// Reset (synchronous, active low) empties the list; the RAM needs no clearing.
module sequential_list_engine_unit #(
    parameter int DEPTH      = sle_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sle_in_if.sink    i_cmd,
    sle_out_if.source o_res
);
    import sle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_INS   = 8'b00000010,
        S_DEL   = 8'b00000100,
        S_LOC   = 8'b00001000,
        S_PRD   = 8'b00010000,
        S_PCHK  = 8'b00100000,
        S_DONE  = 8'b01000000,
        S_WAIT  = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;       // walking index
    logic [CW-1:0] r_kept, n_kept;
    logic [CW-1:0] r_chk, n_chk;
    logic [CW-1:0] r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_word, n_word;
    logic [STATUS_W-1:0] r_st, n_st;
    logic [CW-1:0] r_where, n_where;
    logic r_pend, n_pend;          // a read issued last cycle
    t_out_beat r_out;
    logic r_ovalid;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata;

    sle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    always_comb begin
        n_state = r_state; n_count = r_count; n_k = r_k; n_kept = r_kept;
        n_chk = r_chk; n_pos = r_pos; n_word = r_word; n_st = r_st;
        n_where = r_where; n_pend = 1'b0;
        we = 1'b0; waddr = '0; wdata = r_word; raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_word  = DATA_WIDTH'(signed'(i_cmd.data.value));
                    n_pos   = CW'(i_cmd.data.pos);
                    n_st    = ST_OK;
                    n_where = '0;
                    n_state = S_DONE;
                    unique case (i_cmd.data.cmd)
                        CMD_INSERT: begin
                            if (r_count == CW'(DEPTH)) n_st = ST_FULL;
                            else if (XW'(i_cmd.data.pos) > XW'(r_count)) n_st = ST_BADPOS;
                            else begin n_k = r_count; n_state = S_INS; end
                        end
                        CMD_DELETE: begin
                            if (XW'(i_cmd.data.pos) >= XW'(r_count)) n_st = ST_BADPOS;
                            else begin n_k = CW'(i_cmd.data.pos) + 1'b1; n_state = S_DEL; end
                        end
                        CMD_LOCATE: begin n_k = '0; n_state = S_LOC; end
                        CMD_PURGE: begin
                            if (r_count == '0) n_st = ST_EMPTY;
                            else begin n_k = '0; n_kept = '0; n_state = S_PRD; end
                        end
                        CMD_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            S_INS: begin
                // Read entry k-1, then write it to k on the next cycle.
                if (r_pend) begin
                    we = 1'b1; waddr = AW'(r_k); wdata = rdata;
                    n_k = r_k - 1'b1;
                end else if (r_k > r_pos) begin
                    raddr = AW'(r_k - 1'b1); n_pend = 1'b1;
                end else begin
                    we = 1'b1; waddr = AW'(r_pos); wdata = r_word;
                    n_count = r_count + 1'b1; n_state = S_DONE;
                end
            end
            S_DEL: begin
                if (r_pend) begin
                    we = 1'b1; waddr = AW'(r_k - 1'b1); wdata = rdata;
                    n_k = r_k + 1'b1;
                end else if (r_k < r_count) begin
                    raddr = AW'(r_k); n_pend = 1'b1;
                end else begin
                    n_count = r_count - 1'b1; n_state = S_DONE;
                end
            end
            S_LOC: begin
                raddr = AW'(r_k + 1'b1);
                if (r_pend && rdata == r_word) begin
                    n_where = r_k; n_state = S_DONE;
                end else begin
                    if (r_pend) n_k = r_k + 1'b1;
                    if ((r_pend ? r_k + 1'b1 : r_k) < r_count) begin
                        raddr = AW'(r_pend ? r_k + 1'b1 : r_k); n_pend = 1'b1;
                    end else begin
                        n_st = ST_NOTFOUND; n_state = S_DONE;
                    end
                end
            end
            S_PRD: begin
                // Fetch entry k into r_word, then compare with kept entries.
                if (r_pend) begin
                    n_word = rdata; n_chk = '0; n_state = S_PCHK;
                end else if (r_k < r_count) begin
                    raddr = AW'(r_k); n_pend = 1'b1;
                end else begin
                    n_count = r_kept; n_state = S_DONE;
                end
            end
            S_PCHK: begin
                if (r_pend && rdata == r_word) begin
                    n_k = r_k + 1'b1; n_state = S_PRD;
                end else begin
                    if (r_pend) n_chk = r_chk + 1'b1;
                    if ((r_pend ? r_chk + 1'b1 : r_chk) < r_kept) begin
                        raddr = AW'(r_pend ? r_chk + 1'b1 : r_chk); n_pend = 1'b1;
                    end else begin
                        we = 1'b1; waddr = AW'(r_kept); wdata = r_word;
                        n_kept = r_kept + 1'b1; n_k = r_k + 1'b1; n_state = S_PRD;
                    end
                end
            end
            S_DONE: n_state = S_WAIT;
            S_WAIT: if (!r_ovalid || o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_pend <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_pend <= n_pend;
            if (r_state == S_WAIT && (!r_ovalid || o_res.ready)) r_ovalid <= 1'b1;
            else if (o_res.ready) r_ovalid <= 1'b0;
        end
        r_k <= n_k; r_kept <= n_kept; r_chk <= n_chk; r_pos <= n_pos;
        r_word <= n_word; r_st <= n_st; r_where <= n_where;
        if (r_state == S_WAIT && (!r_ovalid || o_res.ready)) begin
            r_out.status      <= r_st;
            r_out.found_index <= FIDX_W'(r_where);
            r_out.length      <= LEN_W'(r_count);
            r_out.is_empty    <= (r_count == '0);
        end
    end
endmodule

### rtl/sle_checker.sv
module sle_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input sle_pkg::t_out_beat out_data
);
    import sle_pkg::*;

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_data.is_empty == (out_data.length == '0)))
        else $error("empty flag disagrees with length");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    a_fidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.found_index == '0)
        else $error("index set on failed command");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a beat while busy");
endmodule

bind sequential_list_engine_unit sle_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_cmd.valid), .in_ready(i_cmd.ready),
    .out_valid(o_res.valid), .out_ready(o_res.ready), .out_data(o_res.data)
);
